// ===== hw/rtl/ppl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_pkg: shared definitions of the phase lock monitor
// Widths, register indexes, verdict codes and the request and response
// structs of the shared divider.
// ----------------------------------------------------------------------------
package ppl_pkg;

	// Timestamp and period widths
	localparam int TIME_W  = 64;
	localparam int PER_W   = 20;
	localparam int TOL_W   = PER_W + 1;
	localparam int JIT_W   = 20;
	localparam int STAT_W  = 32;
	localparam int WARM_W  = 16;
	localparam int ERRC_W  = 4;

	// Shared divider: divisor covers both the period and the sample count
	localparam int DIVR_W  = STAT_W;
	localparam int STEP_W  = $clog2(TIME_W + 1);
	localparam int PROD_W  = JIT_W + STAT_W;

	// Configuration port
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_TOL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADAPT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_LIM  = 3'd5;

	// Register reset values
	localparam logic [PER_W-1:0]  RST_INTERVAL = 20'd15625;
	localparam logic [PER_W-1:0]  RST_BASE_TOL = 20'd1562;
	localparam logic [PER_W-1:0]  RST_MAX_TOL  = 20'd10000;
	localparam logic [WARM_W-1:0] RST_WARMUP   = 16'd1000;
	localparam logic [WARM_W-1:0] RST_ADAPT    = 16'd100;
	localparam logic [ERRC_W-1:0] RST_ERR_LIM  = 4'd3;

	// Verdict codes
	localparam logic [1:0] V_COHERENT = 2'd0;
	localparam logic [1:0] V_SOFT     = 2'd1;
	localparam logic [1:0] V_ROLLBACK = 2'd2;
	localparam logic [1:0] V_RESUME   = 2'd3;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DIVR_W-1:0] rem_init;
		logic [TIME_W-1:0] dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVR_W-1:0] rem;
		logic [TIME_W-1:0] quot;
	} div_rsp_t;

	// Saturating increment of a statistics counter
	function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
		return (v == '1) ? v : v + STAT_W'(1);
	endfunction

endpackage

// ===== hw/rtl/ppl_evt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_evt_if: event channel
// Carries one timestamped check or resume request per transaction.
// ----------------------------------------------------------------------------
interface ppl_evt_if import ppl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [TIME_W-1:0] event_time;

	modport source (output valid, req_type, event_time, input ready);
	modport sink   (input valid, req_type, event_time, output ready);
endinterface

// ===== hw/rtl/ppl_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_res_if: result channel
// Carries the verdict and the statistics snapshot of one event.
// ----------------------------------------------------------------------------
interface ppl_res_if import ppl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        verdict;
	logic [PER_W-1:0]  phase_offset;
	logic [TOL_W-1:0]  tolerance_used;
	logic [ERRC_W-1:0] errors_now;
	logic [STAT_W-1:0] resyncs_total;
	logic [STAT_W-1:0] checks_total;
	logic [JIT_W-1:0]  jitter_least;
	logic [JIT_W-1:0]  jitter_most;
	logic [JIT_W-1:0]  jitter_mean;

	modport source (output valid, verdict, phase_offset, tolerance_used, errors_now,
		resyncs_total, checks_total, jitter_least, jitter_most, jitter_mean,
		input ready);
	modport sink (input valid, verdict, phase_offset, tolerance_used, errors_now,
		resyncs_total, checks_total, jitter_least, jitter_most, jitter_mean,
		output ready);
endinterface

// ===== hw/rtl/ppl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_div: shared restoring divider
// Retires one quotient bit per cycle for a programmed number of steps,
// starting from a preloaded partial remainder.
// ----------------------------------------------------------------------------
module ppl_div import ppl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIVR_W-1:0] rem_q;
	logic [TIME_W-1:0] sh_q;
	logic [DIVR_W-1:0] dvs_q;

	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              ge;

	// Trial subtraction of one step
	assign trial = {rem_q, sh_q[TIME_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - STEP_W'(1);
			busy_q <= (cnt_q != STEP_W'(1));
			done_q <= (cnt_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			sh_q  <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			sh_q  <= {sh_q[TIME_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quot = sh_q;

endmodule

// ===== hw/rtl/periodic_phase_lock_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_phase_lock_monitor: phase lock monitor for periodic events
// Checks event timestamps against a configured period, keeps jitter
// statistics, adapts the tolerance and reports resync and rollback verdicts.
// ----------------------------------------------------------------------------
// The block takes one event at a time and is not ready while it works on it.
// Resume, warmup and first-lock events go straight from the decision step to
// the result. A checked event runs the phase error through a shared restoring
// divider that retires one bit per cycle; an error below the base tolerance
// adds a multiply and a mean division, and an incoherent event that does not
// roll back adds a second modulo for the soft resync. A finished result waits
// in an output register, so the next event is accepted while it is still
// pending.
module periodic_phase_lock_monitor import ppl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	ppl_evt_if.sink              evt,
	ppl_res_if.source            res
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECIDE = 4'd1;
	localparam logic [3:0] S_MODW   = 4'd2;
	localparam logic [3:0] S_MUL    = 4'd3;
	localparam logic [3:0] S_MEAN   = 4'd4;
	localparam logic [3:0] S_MEANW  = 4'd5;
	localparam logic [3:0] S_TOL    = 4'd6;
	localparam logic [3:0] S_JUDGE  = 4'd7;
	localparam logic [3:0] S_RESW   = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	// Configuration registers
	logic [PER_W-1:0]  interval_q;
	logic [PER_W-1:0]  base_q;
	logic [PER_W-1:0]  maxtol_q;
	logic [WARM_W-1:0] warm_cfg_q;
	logic [WARM_W-1:0] adapt_q;
	logic [ERRC_W-1:0] limit_q;

	// Monitor state
	logic [3:0]        state_q;
	logic [TIME_W-1:0] lock_q;
	logic [WARM_W-1:0] warm_q;
	logic [ERRC_W-1:0] errc_q;
	logic [STAT_W-1:0] resync_q;
	logic [STAT_W-1:0] check_q;
	logic [STAT_W-1:0] sample_q;
	logic [JIT_W-1:0]  least_q;
	logic [JIT_W-1:0]  most_q;
	logic [JIT_W-1:0]  mean_q;

	// Working registers of the current transaction
	logic              req_type_q;
	logic [TIME_W-1:0] time_q;
	logic [PER_W-1:0]  err_q;
	logic [TOL_W-1:0]  tol_q;
	logic [1:0]        verdict_q;
	logic [PROD_W-1:0] prod_q;

	// Result register
	logic              out_valid_q;
	logic [1:0]        o_verdict_q;
	logic [PER_W-1:0]  o_offset_q;
	logic [TOL_W-1:0]  o_tol_q;
	logic [ERRC_W-1:0] o_errc_q;
	logic [STAT_W-1:0] o_resync_q;
	logic [STAT_W-1:0] o_check_q;
	logic [JIT_W-1:0]  o_least_q;
	logic [JIT_W-1:0]  o_most_q;
	logic [JIT_W-1:0]  o_mean_q;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic              accept;
	logic              load_out;
	logic [PER_W-1:0]  period;
	logic [PER_W-1:0]  jit;
	logic [PROD_W-1:0] mean_sum;
	logic              incoh;
	logic [ERRC_W-1:0] err_inc;
	logic              roll;
	logic [TOL_W-1:0]  dbl;
	logic [TOL_W-1:0]  tol_lo;
	logic [TOL_W-1:0]  tol_adapt;
	logic              checking;

	assign accept   = evt.valid && evt.ready;
	assign load_out = (state_q == S_FIN) && (!out_valid_q || res.ready);

	// Zero period acts as one
	assign period   = (interval_q == '0) ? PER_W'(1) : interval_q;
	assign jit      = div_rsp.rem[PER_W-1:0];
	assign mean_sum = prod_q + PROD_W'(err_q);
	assign checking = !req_type_q && (warm_q >= warm_cfg_q) && (lock_q != '0);

	// Tolerance: twice the largest jitter, floored at base, capped at max
	assign dbl       = {most_q, 1'b0};
	assign tol_lo    = (dbl < TOL_W'(base_q)) ? TOL_W'(base_q) : dbl;
	assign tol_adapt = (tol_lo > TOL_W'(maxtol_q)) ? TOL_W'(maxtol_q) : tol_lo;

	// Incoherence test and error count step
	assign incoh   = (TOL_W'(err_q) > tol_q) && (TOL_W'(period - err_q) > tol_q);
	assign err_inc = (errc_q == '1) ? errc_q : errc_q + ERRC_W'(1);
	assign roll    = err_inc >= limit_q;

	// Issue work to the shared divider
	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_DECIDE: begin
				if (checking) begin
					div_req.start    = 1'b1;
					div_req.steps    = STEP_W'(TIME_W);
					div_req.dividend = time_q - lock_q;
					div_req.divisor  = DIVR_W'(period);
				end
			end
			S_MEAN: begin
				div_req.start    = 1'b1;
				div_req.steps    = STEP_W'(JIT_W);
				div_req.rem_init = mean_sum[PROD_W-1:JIT_W];
				div_req.dividend = {mean_sum[JIT_W-1:0], {(TIME_W - JIT_W){1'b0}}};
				div_req.divisor  = sample_q;
			end
			S_JUDGE: begin
				if (incoh && !roll) begin
					div_req.start    = 1'b1;
					div_req.steps    = STEP_W'(TIME_W);
					div_req.dividend = time_q;
					div_req.divisor  = DIVR_W'(period);
				end
			end
			default: begin
			end
		endcase
	end

	ppl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= RST_INTERVAL;
			base_q     <= RST_BASE_TOL;
			maxtol_q   <= RST_MAX_TOL;
			warm_cfg_q <= RST_WARMUP;
			adapt_q    <= RST_ADAPT;
			limit_q    <= RST_ERR_LIM;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_INTERVAL: interval_q <= cfg_data[PER_W-1:0];
				REG_BASE_TOL: base_q     <= cfg_data[PER_W-1:0];
				REG_MAX_TOL:  maxtol_q   <= cfg_data[PER_W-1:0];
				REG_WARMUP:   warm_cfg_q <= cfg_data[WARM_W-1:0];
				REG_ADAPT:    adapt_q    <= cfg_data[WARM_W-1:0];
				REG_ERR_LIM:  limit_q    <= cfg_data[ERRC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			lock_q   <= '0;
			warm_q   <= '0;
			errc_q   <= '0;
			resync_q <= '0;
			check_q  <= '0;
			sample_q <= '0;
			least_q  <= '0;
			most_q   <= '0;
			mean_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					priority if (req_type_q) begin
						lock_q   <= '0;
						errc_q   <= '0;
						warm_q   <= '0;
						resync_q <= sat_inc(resync_q);
						state_q  <= S_FIN;
					end else if (warm_q < warm_cfg_q) begin
						warm_q <= warm_q + WARM_W'(1);
						if (lock_q == '0) lock_q <= time_q;
						state_q <= S_FIN;
					end else if (lock_q == '0) begin
						lock_q   <= time_q;
						resync_q <= sat_inc(resync_q);
						state_q  <= S_FIN;
					end else begin
						state_q <= S_MODW;
					end
				end
				S_MODW: begin
					if (div_rsp.done) begin
						if (jit < base_q) begin
							sample_q <= sat_inc(sample_q);
							if (jit < least_q || least_q == '0) least_q <= jit;
							if (jit > most_q) most_q <= jit;
							state_q <= S_MUL;
						end else begin
							state_q <= S_TOL;
						end
					end
				end
				S_MUL:   state_q <= S_MEAN;
				S_MEAN:  state_q <= S_MEANW;
				S_MEANW: begin
					if (div_rsp.done) begin
						mean_q  <= div_rsp.quot[JIT_W-1:0];
						state_q <= S_TOL;
					end
				end
				S_TOL:   state_q <= S_JUDGE;
				S_JUDGE: begin
					if (incoh) begin
						if (roll) begin
							lock_q  <= '0;
							errc_q  <= '0;
							warm_q  <= '0;
							state_q <= S_FIN;
						end else begin
							errc_q  <= err_inc;
							state_q <= S_RESW;
						end
					end else begin
						lock_q  <= time_q - TIME_W'(err_q);
						if (errc_q != '0) errc_q <= errc_q - ERRC_W'(1);
						check_q <= sat_inc(check_q);
						state_q <= S_FIN;
					end
				end
				S_RESW: begin
					if (div_rsp.done) begin
						lock_q   <= time_q - TIME_W'(div_rsp.rem);
						resync_q <= sat_inc(resync_q);
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the transaction and its intermediate values
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= evt.req_type;
			time_q     <= evt.event_time;
			err_q      <= '0;
			tol_q      <= '0;
			verdict_q  <= V_COHERENT;
		end
		if (state_q == S_DECIDE && req_type_q) verdict_q <= V_RESUME;
		if (state_q == S_MODW && div_rsp.done) err_q <= jit;
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(mean_q) * PROD_W'(sample_q - STAT_W'(1));
		end
		if (state_q == S_TOL) begin
			tol_q <= (sample_q < STAT_W'(adapt_q)) ? TOL_W'(base_q) : tol_adapt;
		end
		if (state_q == S_JUDGE && incoh) verdict_q <= roll ? V_ROLLBACK : V_SOFT;
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_verdict_q <= verdict_q;
			o_offset_q  <= err_q;
			o_tol_q     <= tol_q;
			o_errc_q    <= errc_q;
			o_resync_q  <= resync_q;
			o_check_q   <= check_q;
			o_least_q   <= least_q;
			o_most_q    <= most_q;
			o_mean_q    <= mean_q;
		end
	end

	assign evt.ready          = (state_q == S_IDLE);
	assign res.valid          = out_valid_q;
	assign res.verdict        = o_verdict_q;
	assign res.phase_offset   = o_offset_q;
	assign res.tolerance_used = o_tol_q;
	assign res.errors_now     = o_errc_q;
	assign res.resyncs_total  = o_resync_q;
	assign res.checks_total   = o_check_q;
	assign res.jitter_least   = o_least_q;
	assign res.jitter_most    = o_most_q;
	assign res.jitter_mean    = o_mean_q;

`ifndef SYNTHESIS
	// An accepted transaction moves straight to the decision step
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DECIDE)
		else $error("accepted transaction did not reach the decision step");

	// A new result only appears after the finish step
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside the finish step");

	// Divider completion only lands in a waiting state
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_MODW || state_q == S_MEANW || state_q == S_RESW))
		else $error("divider finished with nobody waiting");

	// A rollback clears the error count
	a_rollback_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.verdict == V_ROLLBACK) |-> res.errors_now == '0)
		else $error("rollback reported with a live error count");

	// Recorded jitter bounds stay ordered
	a_jitter_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.jitter_least != '0) |-> res.jitter_most >= res.jitter_least)
		else $error("jitter maximum below jitter minimum");
`endif

endmodule

// ===== sim/tb_periodic_phase_lock_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_phase_lock_monitor: self-checking bench of the phase lock monitor
// A scoreboard class predicts every verdict and statistics snapshot from its
// own copy of the lock state and registers. Plain tasks drive event
// transactions and register writes under random back-pressure on both
// channels. The run covers a directed opening and random phases over
// several register settings.
// ----------------------------------------------------------------------------
module tb_periodic_phase_lock_monitor import ppl_pkg::*; ();

	localparam bit REQ_CHECK  = 1'b0;
	localparam bit REQ_RESUME = 1'b1;
	localparam int MAX_GAP    = 13;

	// One expected or observed result transaction
	typedef struct {
		logic [1:0]        verdict;
		logic [PER_W-1:0]  phase_offset;
		logic [TOL_W-1:0]  tolerance_used;
		logic [ERRC_W-1:0] errors_now;
		logic [STAT_W-1:0] resyncs_total;
		logic [STAT_W-1:0] checks_total;
		logic [JIT_W-1:0]  jitter_least;
		logic [JIT_W-1:0]  jitter_most;
		logic [JIT_W-1:0]  jitter_mean;
	} lock_result_t;

	// One register setting
	typedef struct {
		bit [PER_W-1:0]  interval;
		bit [PER_W-1:0]  base_tol;
		bit [PER_W-1:0]  max_tol;
		bit [WARM_W-1:0] warmup;
		bit [WARM_W-1:0] adapt;
		bit [ERRC_W-1:0] err_limit;
	} lock_cfg_t;

	// ------------------------------------------------------------------------
	// Scoreboard: lock state predictor and queue of expected snapshots
	// ------------------------------------------------------------------------
	class phase_lock_scoreboard;
		bit [PER_W-1:0]  interval;
		bit [PER_W-1:0]  base_tol;
		bit [PER_W-1:0]  max_tol;
		bit [WARM_W-1:0] warmup;
		bit [WARM_W-1:0] adapt;
		bit [ERRC_W-1:0] err_limit;

		bit [TIME_W-1:0] lock_point;
		bit [WARM_W-1:0] warm_seen;
		bit [ERRC_W-1:0] err_tally;
		bit [STAT_W-1:0] resync_tally;
		bit [STAT_W-1:0] check_tally;
		bit [STAT_W-1:0] sample_tally;
		bit [JIT_W-1:0]  least_jit;
		bit [JIT_W-1:0]  most_jit;
		bit [JIT_W-1:0]  mean_jit;

		lock_result_t    snapshot_q[$];
		int              fails;
		int              events_seen;
		int              verdict_hits[4];

		function new();
			interval     = RST_INTERVAL;
			base_tol     = RST_BASE_TOL;
			max_tol      = RST_MAX_TOL;
			warmup       = RST_WARMUP;
			adapt        = RST_ADAPT;
			err_limit    = RST_ERR_LIM;
			lock_point   = '0;
			warm_seen    = '0;
			err_tally    = '0;
			resync_tally = '0;
			check_tally  = '0;
			sample_tally = '0;
			least_jit    = '0;
			most_jit     = '0;
			mean_jit     = '0;
			fails        = 0;
			events_seen  = 0;
			foreach (verdict_hits[i])
				verdict_hits[i] = 0;
		endfunction

		function int pending();
			return snapshot_q.size();
		endfunction

		function bit [STAT_W-1:0] bump(bit [STAT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_INTERVAL: interval  = data[PER_W-1:0];
				REG_BASE_TOL: base_tol  = data[PER_W-1:0];
				REG_MAX_TOL:  max_tol   = data[PER_W-1:0];
				REG_WARMUP:   warmup    = data[WARM_W-1:0];
				REG_ADAPT:    adapt     = data[WARM_W-1:0];
				REG_ERR_LIM:  err_limit = data[ERRC_W-1:0];
				default: ;
			endcase
		endfunction

		// Fold one jitter sample into min, max and running mean
		function void note_jitter(bit [TIME_W-1:0] j);
			bit [63:0] acc;
			bit [63:0] cnt;
			sample_tally = bump(sample_tally);
			if (j < least_jit || least_jit == 0)
				least_jit = j[JIT_W-1:0];
			if (j > most_jit)
				most_jit = j[JIT_W-1:0];
			cnt      = 64'(sample_tally);
			acc      = 64'(mean_jit) * (cnt - 1) + j;
			acc      = acc / cnt;
			mean_jit = acc[JIT_W-1:0];
		endfunction

		// Base tolerance until enough samples, then twice the worst jitter, floored at base and capped at max
		function bit [63:0] tolerance();
			bit [63:0] t;
			if (sample_tally < adapt)
				return 64'(base_tol);
			t = 64'(most_jit) << 1;
			if (t < base_tol)
				t = 64'(base_tol);
			if (t > max_tol)
				t = 64'(max_tol);
			return t;
		endfunction

		// Predict the snapshot of one accepted event transaction
		function void note_event(bit req, bit [TIME_W-1:0] t);
			bit [63:0]    per;
			bit [63:0]    err;
			bit [63:0]    tol;
			bit [1:0]     v;
			lock_result_t r;
			per = (interval == 0) ? 64'd1 : 64'(interval);
			err = '0;
			tol = '0;
			v   = V_COHERENT;
			if (req == REQ_RESUME) begin
				lock_point   = '0;
				err_tally    = '0;
				warm_seen    = '0;
				resync_tally = bump(resync_tally);
				v            = V_RESUME;
			end else if (warm_seen < warmup) begin
				warm_seen++;
				if (lock_point == 0)
					lock_point = t;
			end else if (lock_point == 0) begin
				lock_point   = t;
				resync_tally = bump(resync_tally);
			end else begin
				err = (t - lock_point) % per;
				if (err < base_tol)
					note_jitter(err);
				tol = tolerance();
				if (err > tol && (per - err) > tol) begin
					if (err_tally != '1)
						err_tally++;
					if (err_tally >= err_limit) begin
						lock_point = '0;
						err_tally  = '0;
						warm_seen  = '0;
						v          = V_ROLLBACK;
					end else begin
						lock_point   = t - (t % per);
						resync_tally = bump(resync_tally);
						v            = V_SOFT;
					end
				end else begin
					lock_point = t - err;
					if (err_tally > 0)
						err_tally--;
					check_tally = bump(check_tally);
				end
			end
			r.verdict        = v;
			r.phase_offset   = err[PER_W-1:0];
			r.tolerance_used = tol[TOL_W-1:0];
			r.errors_now     = err_tally;
			r.resyncs_total  = resync_tally;
			r.checks_total   = check_tally;
			r.jitter_least   = least_jit;
			r.jitter_most    = most_jit;
			r.jitter_mean    = mean_jit;
			snapshot_q.push_back(r);
			events_seen++;
		endfunction

		function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
			if (got_v !== exp_v) begin
				fails++;
				$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name,
					exp_v, got_v);
			end
		endfunction

		// Compare one result transaction against the oldest prediction
		function void check_result(lock_result_t got);
			lock_result_t exp_r;
			if (snapshot_q.size() == 0) begin
				fails++;
				$display("%0t ns: result with nothing outstanding, verdict %0d", $time,
					got.verdict);
				return;
			end
			exp_r = snapshot_q.pop_front();
			verdict_hits[exp_r.verdict]++;
			compare_field("verdict",        exp_r.verdict,        got.verdict);
			compare_field("phase_offset",   exp_r.phase_offset,   got.phase_offset);
			compare_field("tolerance_used", exp_r.tolerance_used, got.tolerance_used);
			compare_field("errors_now",     exp_r.errors_now,     got.errors_now);
			compare_field("resyncs_total",  exp_r.resyncs_total,  got.resyncs_total);
			compare_field("checks_total",   exp_r.checks_total,   got.checks_total);
			compare_field("jitter_least",   exp_r.jitter_least,   got.jitter_least);
			compare_field("jitter_most",    exp_r.jitter_most,    got.jitter_most);
			compare_field("jitter_mean",    exp_r.jitter_mean,    got.jitter_mean);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	bit                   no_idle;

	ppl_evt_if evt_ch ();
	ppl_res_if res_ch ();

	phase_lock_scoreboard sb = new();

	periodic_phase_lock_monitor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.evt      (evt_ch),
		.res      (res_ch)
	);

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Hard limit on run length
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic lock_cfg_t make_cfg(int unsigned interval, int unsigned base_tol,
			int unsigned max_tol, int unsigned warmup, int unsigned adapt,
			int unsigned err_limit);
		lock_cfg_t c;
		c.interval  = PER_W'(interval);
		c.base_tol  = PER_W'(base_tol);
		c.max_tol   = PER_W'(max_tol);
		c.warmup    = WARM_W'(warmup);
		c.adapt     = WARM_W'(adapt);
		c.err_limit = ERRC_W'(err_limit);
		return c;
	endfunction

	// Random setting, with periods spread over the whole range
	function automatic lock_cfg_t random_cfg();
		int unsigned per;
		per = $urandom_range(1, (1 << $urandom_range(1, PER_W)) - 1);
		return make_cfg(per, $urandom_range(0, per / 3), $urandom_range(0, per),
			$urandom_range(0, 6), $urandom_range(0, 30), $urandom_range(0, 15));
	endfunction

	// Push one event transaction, holding valid until it is taken
	task automatic send_event(input bit req, input bit [TIME_W-1:0] t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid      <= 1'b1;
		evt_ch.req_type   <= req;
		evt_ch.event_time <= t;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
		sb.note_event(req, t);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Wait until every predicted result has come back
	task automatic drain();
		evt_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Reprogram all registers while the block is idle
	task automatic apply_cfg(input lock_cfg_t c);
		drain();
		write_reg(REG_INTERVAL, CFG_W'(c.interval));
		write_reg(REG_BASE_TOL, CFG_W'(c.base_tol));
		write_reg(REG_MAX_TOL,  CFG_W'(c.max_tol));
		write_reg(REG_WARMUP,   CFG_W'(c.warmup));
		write_reg(REG_ADAPT,    CFG_W'(c.adapt));
		write_reg(REG_ERR_LIM,  CFG_W'(c.err_limit));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly periodic events around the current lock point, with jitter,
	// early arrivals, bursts of stray events, resumes and random noise
	task automatic run_random(input int count);
		int unsigned     sel;
		int unsigned     burst;
		int unsigned     per;
		int unsigned     near_lim;
		bit [TIME_W-1:0] anchor;
		bit [TIME_W-1:0] t;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			per      = (sb.interval == 0) ? 1 : sb.interval;
			near_lim = (sb.base_tol < per) ? sb.base_tol : per - 1;
			sel      = $urandom_range(0, 99);
			if (burst == 0 && sel < 3) begin
				send_event(REQ_RESUME, {$urandom, $urandom});
			end else if (burst == 0 && sel < 8) begin
				send_event(REQ_CHECK, {$urandom, $urandom});
			end else if (burst == 0 && sel < 10) begin
				send_event(REQ_CHECK, '1 - TIME_W'($urandom_range(0, 3 * per)));
			end else begin
				anchor = (sb.lock_point != 0) ? sb.lock_point : {$urandom, $urandom};
				t = anchor + TIME_W'($urandom_range(1, 4)) * TIME_W'(per);
				if (burst > 0) begin
					t += $urandom_range(0, per - 1);
					burst--;
				end else if (sel < 58) begin
					t += $urandom_range(0, near_lim);
				end else if (sel < 78) begin
					t -= $urandom_range(0, near_lim);
				end else if (sel < 90) begin
					t += $urandom_range(0, per - 1);
				end else begin
					burst = $urandom_range(1, 16);
				end
				send_event(REQ_CHECK, t);
			end
		end
	endtask

	// Result side: random stalls, capture and check each transaction
	initial begin
		lock_result_t got;
		int           stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
			got.verdict        = res_ch.verdict;
			got.phase_offset   = res_ch.phase_offset;
			got.tolerance_used = res_ch.tolerance_used;
			got.errors_now     = res_ch.errors_now;
			got.resyncs_total  = res_ch.resyncs_total;
			got.checks_total   = res_ch.checks_total;
			got.jitter_least   = res_ch.jitter_least;
			got.jitter_most    = res_ch.jitter_most;
			got.jitter_mean    = res_ch.jitter_mean;
			sb.check_result(got);
		end
	end

	// Stimulus
	initial begin
		lock_cfg_t plan[$];
		int        plan_items[$];
		int        waited;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_idx           <= REG_INTERVAL;
		cfg_data          <= '0;
		evt_ch.valid      <= 1'b0;
		evt_ch.req_type   <= REQ_CHECK;
		evt_ch.event_time <= '0;
		no_idle = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: a warmup event, then a resume
		send_event(REQ_CHECK, 64'd12345);
		send_event(REQ_RESUME, '1);

		// Warmup across time zero and all ones, wrapped check, early arrival,
		// adaptation, soft resync, rollback, lock point landing on zero
		apply_cfg(make_cfg(1000, 100, 300, 2, 3, 2));
		send_event(REQ_CHECK, 64'd0);
		send_event(REQ_CHECK, '1);
		send_event(REQ_CHECK, 64'd5);
		send_event(REQ_CHECK, 64'd1010);
		send_event(REQ_CHECK, 64'd2996);
		send_event(REQ_CHECK, 64'd4049);
		send_event(REQ_CHECK, 64'd5499);
		send_event(REQ_CHECK, 64'd6010);
		send_event(REQ_CHECK, 64'd7500);
		send_event(REQ_CHECK, 64'd8600);
		send_event(REQ_CHECK, 64'd1000000);
		send_event(REQ_CHECK, 64'd1001000);
		send_event(REQ_CHECK, 64'd500);
		send_event(REQ_CHECK, 64'd777);
		send_event(REQ_RESUME, 64'd0);
		send_event(REQ_CHECK, 64'h8000_0000_0000_0000);
		send_event(REQ_CHECK, 64'h8000_0000_0000_03E8);
		// Exact hit: a zero jitter sample
		send_event(REQ_CHECK, 64'h8000_0000_0000_0BB8);

		// Zero interval behaves as a period of one
		apply_cfg(make_cfg(0, 1500, 20, 0, 0, 1));
		send_event(REQ_CHECK, 64'h0123_4567_89AB_CDEF);
		send_event(REQ_CHECK, 64'hFEDC_BA98_7654_3210);

		// Zero error limit with base tolerance above the cap
		apply_cfg(make_cfg(100, 500, 20, 0, 0, 0));
		send_event(REQ_CHECK, 64'd100000);
		send_event(REQ_CHECK, 64'd100050);
		send_event(REQ_CHECK, 64'd100100);
		send_event(REQ_CHECK, 64'd100205);

		// Random phases over a spread of settings
		plan.push_back(make_cfg(15625, 1562, 10000, 4, 20, 3));      plan_items.push_back(180);
		plan.push_back(make_cfg(1048575, 2000, 1048575, 0, 0, 15));  plan_items.push_back(160);
		plan.push_back(make_cfg(0, 0, 0, 1, 65535, 1));              plan_items.push_back(60);
		plan.push_back(make_cfg(1000, 200, 150, 2, 5, 0));           plan_items.push_back(150);
		plan.push_back(make_cfg(250, 40, 60, 3, 8, 4));              plan_items.push_back(160);
		plan.push_back(random_cfg());                                plan_items.push_back(160);
		plan.push_back(make_cfg(1048575, 1048575, 1048575, 65535, 65535, 15));
		plan_items.push_back(30);
		plan.push_back(make_cfg(3, 1, 0, 0, 1, 1));                  plan_items.push_back(100);
		plan.push_back(random_cfg());                                plan_items.push_back(150);
		foreach (plan[p]) begin
			apply_cfg(plan[p]);
			run_random(plan_items[p]);
		end
		evt_ch.valid <= 1'b0;

		// Let outstanding results come back, then watch for strays
		waited = 0;
		while (sb.pending() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.fails++;
			$display("%0t ns: %0d expected results never arrived", $time, sb.pending());
		end

		$display("Covered %0d events over %0d register settings, periods from zero to full scale.",
			sb.events_seen, plan.size() + 4);
		$display("Verdicts seen: %0d coherent, %0d soft resync, %0d rollback, %0d resume.",
			sb.verdict_hits[V_COHERENT], sb.verdict_hits[V_SOFT],
			sb.verdict_hits[V_ROLLBACK], sb.verdict_hits[V_RESUME]);
		if (sb.fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
